/* src/sc1a_pkg.sv */
// Shared constants and lookup tables for the set-1 scancode to ASCII translator.
package sc1a_pkg;

    // Scancode values with a fixed meaning.
    localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT  = 8'h36;
    localparam logic [7:0] KEY_CAPS    = 8'h3A;
    localparam logic [7:0] KEY_UP      = 8'h48;
    localparam logic [7:0] KEY_DOWN    = 8'h50;
    localparam logic [7:0] KEY_LEFT    = 8'h4B;
    localparam logic [7:0] KEY_RIGHT   = 8'h4D;
    localparam logic [7:0] TABLE_LEN   = 8'h3A;
    localparam logic [6:0] KEY_MASK    = 7'h7F;

    // Control codes produced by the arrow keys.
    localparam logic [6:0] CODE_UP     = 7'h01;
    localparam logic [6:0] CODE_DOWN   = 7'h02;
    localparam logic [6:0] CODE_BKSP   = 7'h08;

    // Letter ranges used for case folding.
    localparam logic [6:0] LOWER_A     = 7'h61;
    localparam logic [6:0] LOWER_Z     = 7'h7A;
    localparam logic [6:0] UPPER_A     = 7'h41;
    localparam logic [6:0] UPPER_Z     = 7'h5A;

    localparam int TAB_DEPTH = 58;

    typedef logic [6:0] char_t;

    // Translation without shift, indexed by make code.
    localparam char_t PLAIN_TAB [0:TAB_DEPTH-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Translation with shift held, indexed by make code.
    localparam char_t SHIFT_TAB [0:TAB_DEPTH-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

endpackage

/* src/scancode_set1_to_ascii_unit.sv */
// Top level of the set-1 scancode to ASCII translator.
//
// Usage:
//   The input channel (in_valid, in_stall, scancode) takes one raw set-1
//   scancode byte per word; bit 7 set marks a key release.
//   The output channel (out_valid, out_stall, char_code, cursor_right) gives
//   at most one word per input word. Releases, shift and caps-lock presses and
//   unmapped keys give no output word.
//   The byte lands in the input register, then the table lookup and the flag
//   update go through combinational logic into the output register. One word
//   is accepted per cycle, sustained while the receiver does not stall, set by
//   that single lookup stage.
//   While the receiver stalls, the output word holds; a byte still waiting in
//   the input register then asserts in_stall, so at most one more word is taken.
//   Reset clears both valid flags and the shift and caps-lock flags.
module scancode_set1_to_ascii_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scancode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_code,
    output logic       cursor_right
);

    logic       s1_valid_reg;
    logic [7:0] s1_code_reg;
    logic       shift_reg;
    logic       shift_next;
    logic       caps_reg;
    logic       caps_next;
    logic       out_valid_reg;
    logic [6:0] char_reg;
    logic       right_reg;

    logic       out_free;
    logic       s1_move;
    logic       in_take;
    logic       res_valid;
    logic [6:0] res_char;
    logic       res_right;
    logic       in_range;
    logic [5:0] tab_idx;
    logic [6:0] tab_char;
    logic       upper;

    // Handshake control for the two register stages.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Table lookup for the byte in the input register.
    assign in_range = s1_code_reg < sc1a_pkg::TABLE_LEN;
    assign tab_idx  = in_range ? s1_code_reg[5:0] : 6'd0;
    assign tab_char = shift_reg ? sc1a_pkg::SHIFT_TAB[tab_idx] : sc1a_pkg::PLAIN_TAB[tab_idx];
    assign upper    = shift_reg ^ caps_reg;

    // Decode the byte into a result and the next flag values.
    always_comb
    begin
        res_valid  = 1'b0;
        res_char   = 7'd0;
        res_right  = 1'b0;
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (s1_code_reg[7])
        begin
            if ((s1_code_reg[6:0] & sc1a_pkg::KEY_MASK) == sc1a_pkg::KEY_LSHIFT[6:0] ||
                (s1_code_reg[6:0] & sc1a_pkg::KEY_MASK) == sc1a_pkg::KEY_RSHIFT[6:0])
            begin
                shift_next = 1'b0;
            end
        end
        else
        begin
            unique case (s1_code_reg) inside
                sc1a_pkg::KEY_UP:
                begin
                    res_valid = 1'b1;
                    res_char  = sc1a_pkg::CODE_UP;
                end
                sc1a_pkg::KEY_DOWN:
                begin
                    res_valid = 1'b1;
                    res_char  = sc1a_pkg::CODE_DOWN;
                end
                sc1a_pkg::KEY_LEFT:
                begin
                    res_valid = 1'b1;
                    res_char  = sc1a_pkg::CODE_BKSP;
                end
                sc1a_pkg::KEY_RIGHT:
                begin
                    res_valid = 1'b1;
                    res_right = 1'b1;
                end
                sc1a_pkg::KEY_LSHIFT, sc1a_pkg::KEY_RSHIFT:
                begin
                    shift_next = 1'b1;
                end
                sc1a_pkg::KEY_CAPS:
                begin
                    caps_next = !caps_reg;
                end
                default:
                begin
                    if (in_range && tab_char != 7'd0)
                    begin
                        res_valid = 1'b1;
                        res_char  = tab_char;
                        // Letters follow shift XOR caps lock; bit 5 picks the case.
                        if (tab_char >= sc1a_pkg::LOWER_A && tab_char <= sc1a_pkg::LOWER_Z)
                        begin
                            res_char[5] = !upper;
                        end
                        else if (tab_char >= sc1a_pkg::UPPER_A &&
                                 tab_char <= sc1a_pkg::UPPER_Z)
                        begin
                            res_char[5] = !upper;
                        end
                    end
                end
            endcase
        end
    end

    // Input register and modifier flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            shift_reg    <= 1'b0;
            caps_reg     <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_code_reg <= scancode;
        end
    end

    // Output register: loads when free, holds while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_move && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_move && res_valid)
        begin
            char_reg  <= res_char;
            right_reg <= res_right;
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_reg;
    assign cursor_right = right_reg;

`ifndef NO_ASSERTIONS
    // A cursor-right word never carries a character.
    a_right_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && right_reg |-> char_reg == 7'd0)
        else $error("cursor_right word with nonzero char_code");

    // Caps lock changes only when a caps make code leaves the input register.
    a_caps_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_move && s1_code_reg == sc1a_pkg::KEY_CAPS) |=> $stable(caps_reg))
        else $error("caps flag changed without a caps make code");

    // Shift is set only by a shift make code.
    a_shift_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(shift_reg) |-> $past(s1_move && (s1_code_reg == sc1a_pkg::KEY_LSHIFT ||
                                               s1_code_reg == sc1a_pkg::KEY_RSHIFT)))
        else $error("shift flag set without a shift make code");

    // A release code never produces an output word.
    a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_code_reg[7] |=> !out_valid_reg)
        else $error("release code produced an output word");
`endif

endmodule
